### rtl/lcdd_pkg.sv
// Package for the line central-difference derivative unit.
// Holds constants, register and mode codes, and the payload and job structs.
// No dependencies.
`default_nettype none

package lcdd_pkg;

   localparam int MAX_LINE    = 1024;
   localparam int IDX_W       = $clog2(MAX_LINE);
   localparam int LEN_W       = 11;
   localparam int DATA_W      = 32;
   localparam int PIDX_W      = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int PROD_W      = 2 * DATA_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int FRAC_W      = 16;

   localparam logic [1:0] MODE_PERIODIC  = 2'd0;
   localparam logic [1:0] MODE_GHOST     = 2'd1;
   localparam logic [1:0] MODE_DIRICHLET = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_BOUNDARY_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_LENGTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_NEXT     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PREV     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_END0     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_END1     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_END2     = 3'd6;

   localparam logic [LEN_W-1:0] LINE_LENGTH_RESET = 11'd1024;
   localparam logic [LEN_W-1:0] MIN_LEN           = 11'd3;
   localparam logic [IDX_W-1:0] LAST_MAX          = IDX_W'(MAX_LINE - 1);

   typedef struct packed {
      logic signed [DATA_W-1:0] sample;
      logic signed [DATA_W-1:0] ghost_low;
      logic signed [DATA_W-1:0] ghost_high;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] derivative;
      logic [PIDX_W-1:0]        point_index;
      logic                     line_done;
   } rsp_type;

   typedef struct packed {
      logic [1:0]               boundary_mode;
      logic [LEN_W-1:0]         line_length;
      logic signed [DATA_W-1:0] coef_next;
      logic signed [DATA_W-1:0] coef_prev;
      logic signed [DATA_W-1:0] coef_end0;
      logic signed [DATA_W-1:0] coef_end1;
      logic signed [DATA_W-1:0] coef_end2;
   } cfg_type;

   typedef struct packed {
      logic                     end_stencil;
      logic signed [DATA_W-1:0] x0;
      logic signed [DATA_W-1:0] x1;
      logic signed [DATA_W-1:0] x2;
      logic [PIDX_W-1:0]        point_index;
      logic                     line_done;
   } job_type;

endpackage

`default_nettype wire

### rtl/lcdd_front.sv
// Front end: takes line samples, tracks the position in the line and
// issues one stencil job per cycle while job_ready is high, per completed point.
// Depends on lcdd_pkg.
`default_nettype none

module lcdd_front import lcdd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         job_valid,
   input  wire logic    job_ready,
   output job_type      job_data
);

   localparam int NUM_SLOTS = 5;
   localparam logic [NUM_SLOTS-1:0] SEL_GHOST0 = 5'b00001;
   localparam logic [NUM_SLOTS-1:0] SEL_END0   = 5'b00010;
   localparam logic [NUM_SLOTS-1:0] SEL_INNER  = 5'b00100;
   localparam logic [NUM_SLOTS-1:0] SEL_LASTPT = 5'b01000;
   localparam logic [NUM_SLOTS-1:0] SEL_WRAP0  = 5'b10000;

   logic                     item_valid_ff;
   req_type                  item_ff;
   logic [NUM_SLOTS-1:0]     sent_ff;
   logic [IDX_W-1:0]         position_ff;
   logic signed [DATA_W-1:0] first_ff;
   logic signed [DATA_W-1:0] second_ff;
   logic signed [DATA_W-1:0] older_ff;
   logic signed [DATA_W-1:0] newer_ff;
   logic signed [DATA_W-1:0] ghost_low_ff;

   logic [LEN_W-1:0]     len_lo;
   logic [IDX_W-1:0]     last;
   logic [IDX_W-1:0]     p;
   logic                 is_ghost;
   logic                 is_dir;
   logic                 is_per;
   logic                 at_last;
   logic [NUM_SLOTS-1:0] slots;
   logic [NUM_SLOTS-1:0] pending;
   logic [NUM_SLOTS-1:0] sel;
   logic                 push;
   logic                 retire;
   logic [IDX_W-1:0]     position_in;

   always_comb begin
      len_lo = (cfg.line_length < MIN_LEN) ? MIN_LEN : cfg.line_length;
      if (32'(len_lo) > MAX_LINE) begin
         last = LAST_MAX;
      end else begin
         last = IDX_W'(len_lo - 1'b1);
      end
      p        = (position_ff > last) ? last : position_ff;
      is_ghost = (cfg.boundary_mode == MODE_GHOST);
      is_dir   = (cfg.boundary_mode == MODE_DIRICHLET);
      is_per   = !is_ghost && !is_dir;
      at_last  = (p == last);

      slots[0] = is_ghost && (p == IDX_W'(1));
      slots[1] = is_dir && (p == IDX_W'(2));
      slots[2] = (p >= IDX_W'(2));
      slots[3] = at_last;
      slots[4] = at_last && is_per;

      pending   = item_valid_ff ? (slots & ~sent_ff) : '0;
      sel       = pending & (~pending + 1'b1);
      job_valid = |pending;
      push      = job_valid && job_ready;
      retire    = item_valid_ff && ((pending == '0) || (push && (pending == sel)));
      req_ready = !item_valid_ff || retire;

      position_in = at_last ? '0 : p + 1'b1;
   end

   always_comb begin
      job_data = '0;
      case (sel)
         SEL_GHOST0: begin
            job_data.x0 = item_ff.sample;
            job_data.x1 = ghost_low_ff;
         end
         SEL_END0: begin
            job_data.end_stencil = 1'b1;
            job_data.x0          = first_ff;
            job_data.x1          = second_ff;
            job_data.x2          = item_ff.sample;
         end
         SEL_INNER: begin
            job_data.x0          = item_ff.sample;
            job_data.x1          = older_ff;
            job_data.point_index = PIDX_W'(p - 1'b1);
         end
         SEL_LASTPT: begin
            job_data.point_index = PIDX_W'(last);
            job_data.line_done   = !is_per;
            job_data.x1          = newer_ff;
            if (is_dir) begin
               job_data.end_stencil = 1'b1;
               job_data.x0          = item_ff.sample;
               job_data.x2          = older_ff;
            end else if (is_ghost) begin
               job_data.x0 = item_ff.ghost_high;
            end else begin
               job_data.x0 = first_ff;
            end
         end
         SEL_WRAP0: begin
            job_data.x0        = second_ff;
            job_data.x1        = item_ff.sample;
            job_data.line_done = 1'b1;
         end
         default: begin
            job_data = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         sent_ff       <= '0;
         position_ff   <= '0;
         first_ff      <= '0;
         second_ff     <= '0;
         older_ff      <= '0;
         newer_ff      <= '0;
         ghost_low_ff  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            item_valid_ff <= 1'b1;
         end else if (retire) begin
            item_valid_ff <= 1'b0;
         end
         if (retire) begin
            sent_ff     <= '0;
            position_ff <= position_in;
            older_ff    <= newer_ff;
            newer_ff    <= item_ff.sample;
            if (p == '0) begin
               first_ff     <= item_ff.sample;
               ghost_low_ff <= item_ff.ghost_low;
            end
            if (p == IDX_W'(1)) begin
               second_ff <= item_ff.sample;
            end
         end else if (push) begin
            sent_ff <= sent_ff | sel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

### rtl/lcdd_queue.sv
// Short job queue between the front end and the multiply-add back end.
// Register-based FIFO of stencil jobs. Depends on lcdd_pkg.
`default_nettype none

module lcdd_queue import lcdd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire job_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output job_type      out_data
);

   job_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              wr_en;
   logic              rd_en;

   assign in_ready  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign wr_en     = in_valid && in_ready;
   assign rd_en     = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

### rtl/lcdd_back.sv
// Back end: three-product multiply-add pipeline with rounding and saturation.
// Stages: products, sum with rounding offset, saturated output register.
// Depends on lcdd_pkg.
`default_nettype none

module lcdd_back import lcdd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    job_valid,
   output logic         job_ready,
   input  wire job_type job_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);
   localparam int TOP_LO = FRAC_W + DATA_W - 1;

   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] prod0_ff;
   logic signed [PROD_W-1:0] prod1_ff;
   logic signed [PROD_W-1:0] prod2_ff;
   logic [PIDX_W-1:0]        s1_index_ff;
   logic                     s1_done_ff;

   logic                     s2_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [PIDX_W-1:0]        s2_index_ff;
   logic                     s2_done_ff;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic signed [DATA_W-1:0] coef_a;
   logic signed [DATA_W-1:0] coef_b;
   logic signed [PROD_W-1:0] prod0_in;
   logic signed [PROD_W-1:0] prod1_in;
   logic signed [PROD_W-1:0] prod2_in;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [DATA_W-1:0] derivative_in;
   logic                     out_free;
   logic                     s2_ready;
   logic                     s1_ready;

   always_comb begin
      coef_a   = job_data.end_stencil ? cfg.coef_end0 : cfg.coef_next;
      coef_b   = job_data.end_stencil ? cfg.coef_end1 : cfg.coef_prev;
      prod0_in = coef_a * job_data.x0;
      prod1_in = coef_b * job_data.x1;
      prod2_in = cfg.coef_end2 * job_data.x2;

      sum_in = SUM_W'(prod0_ff) + SUM_W'(prod1_ff) + SUM_W'(prod2_ff) + ROUND_HALF;

      if ((sum_ff[SUM_W-1:TOP_LO] == '0) || (sum_ff[SUM_W-1:TOP_LO] == '1)) begin
         derivative_in = sum_ff[TOP_LO:FRAC_W];
      end else if (sum_ff[SUM_W-1]) begin
         derivative_in = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         derivative_in = {1'b0, {(DATA_W-1){1'b1}}};
      end

      out_free  = !rsp_valid_ff || rsp_ready;
      s2_ready  = !s2_valid_ff || out_free;
      s1_ready  = !s1_valid_ff || s2_ready;
      job_ready = s1_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= job_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid && s1_ready) begin
         prod0_ff    <= prod0_in;
         prod1_ff    <= prod1_in;
         prod2_ff    <= prod2_in;
         s1_index_ff <= job_data.point_index;
         s1_done_ff  <= job_data.line_done;
      end
      if (s1_valid_ff && s2_ready) begin
         sum_ff      <= sum_in;
         s2_index_ff <= s1_index_ff;
         s2_done_ff  <= s1_done_ff;
      end
      if (s2_valid_ff && out_free) begin
         rsp_data_ff.derivative  <= derivative_in;
         rsp_data_ff.point_index <= s2_index_ff;
         rsp_data_ff.line_done   <= s2_done_ff;
      end
   end

endmodule

`default_nettype wire

### rtl/line_central_difference_derivative.sv
// Line central-difference derivative unit, top level with configuration registers.
// Throughput: one sample per cycle while the output is not stalled; a sample that
// completes 2 or 3 points holds the front end until all its jobs are issued, since
// the front end issues one job per cycle.
// Reset clears the line position and pipeline and restores the register reset values.
`default_nettype none

module line_central_difference_derivative import lcdd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_data
);

   cfg_type cfg_ff;
   logic    fq_valid;
   logic    fq_ready;
   job_type fq_data;
   logic    qb_valid;
   logic    qb_ready;
   job_type qb_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.boundary_mode <= MODE_PERIODIC;
         cfg_ff.line_length   <= LINE_LENGTH_RESET;
         cfg_ff.coef_next     <= '0;
         cfg_ff.coef_prev     <= '0;
         cfg_ff.coef_end0     <= '0;
         cfg_ff.coef_end1     <= '0;
         cfg_ff.coef_end2     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BOUNDARY_MODE: cfg_ff.boundary_mode <= csr_data[1:0];
            REG_LINE_LENGTH:   cfg_ff.line_length   <= csr_data[LEN_W-1:0];
            REG_COEF_NEXT:     cfg_ff.coef_next     <= csr_data;
            REG_COEF_PREV:     cfg_ff.coef_prev     <= csr_data;
            REG_COEF_END0:     cfg_ff.coef_end0     <= csr_data;
            REG_COEF_END1:     cfg_ff.coef_end1     <= csr_data;
            REG_COEF_END2:     cfg_ff.coef_end2     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   lcdd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   lcdd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   lcdd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (qb_valid),
      .job_ready (qb_ready),
      .job_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### bench/tb_line_central_difference_derivative.sv
// Testbench for the line central-difference derivative unit.
// Drives samples and register writes, predicts every tagged derivative and checks each one.
// Depends on lcdd_pkg and line_central_difference_derivative.
`timescale 1ns / 1ps

module tb_line_central_difference_derivative;
   import lcdd_pkg::*;

   localparam int RANDOM_ITEMS = 200;
   localparam int DRAIN_CYCLES = 12;
   localparam int QUIET_LIMIT  = 5000;
   localparam int REPORT_LIMIT = 10;

   localparam logic [1:0]           MODE_RESERVED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED    = 3'd7;

   localparam logic signed [65:0] ROUND_HALF = 66'sd32768;
   localparam logic signed [65:0] SAT_HI     = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO     = -66'sd2147483648;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_data = '0;

   bit                   idling = 1'b1;
   int                   error_count = 0;
   int                   quiet_cycles = 0;
   rsp_type              expected_points[$];

   // Mirror of the register file.
   logic [1:0]               mode_q = MODE_PERIODIC;
   logic [LEN_W-1:0]         len_q = LINE_LENGTH_RESET;
   logic signed [DATA_W-1:0] coef_next_q = '0;
   logic signed [DATA_W-1:0] coef_prev_q = '0;
   logic signed [DATA_W-1:0] coef_end0_q = '0;
   logic signed [DATA_W-1:0] coef_end1_q = '0;
   logic signed [DATA_W-1:0] coef_end2_q = '0;

   // Mirror of the line state.
   int unsigned              line_pos = 0;
   logic signed [DATA_W-1:0] x_first = '0;
   logic signed [DATA_W-1:0] x_second = '0;
   logic signed [DATA_W-1:0] x_older = '0;
   logic signed [DATA_W-1:0] x_newer = '0;
   logic signed [DATA_W-1:0] ghost_lo = '0;

   line_central_difference_derivative u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [DATA_W-1:0] weighted_sum(
      input logic signed [DATA_W-1:0] c0, input logic signed [DATA_W-1:0] x0,
      input logic signed [DATA_W-1:0] c1, input logic signed [DATA_W-1:0] x1,
      input logic signed [DATA_W-1:0] c2, input logic signed [DATA_W-1:0] x2);
      logic signed [65:0] acc;
      acc = c0 * x0 + c1 * x1 + c2 * x2 + ROUND_HALF;
      acc = acc >>> FRAC_W;
      if (acc > SAT_HI) begin
         return SAT_HI[DATA_W-1:0];
      end
      if (acc < SAT_LO) begin
         return SAT_LO[DATA_W-1:0];
      end
      return acc[DATA_W-1:0];
   endfunction

   function automatic int unsigned clamped_length();
      int unsigned len;
      len = len_q;
      if (len < MIN_LEN) begin
         len = MIN_LEN;
      end
      if (len > MAX_LINE) begin
         len = MAX_LINE;
      end
      return len;
   endfunction

   function automatic void push_point(input logic signed [DATA_W-1:0] value,
                                      input int unsigned idx);
      rsp_type r;
      r.derivative  = value;
      r.point_index = idx[PIDX_W-1:0];
      r.line_done   = 1'b0;
      expected_points.push_back(r);
   endfunction

   function automatic void predict_derivatives(input req_type item);
      int unsigned              last;
      int unsigned              p;
      logic signed [DATA_W-1:0] s;
      logic signed [DATA_W-1:0] v;
      bit                       ghost;
      bit                       dir;
      s     = item.sample;
      last  = clamped_length() - 1;
      p     = (line_pos > last) ? last : line_pos;
      ghost = (mode_q == MODE_GHOST);
      dir   = (mode_q == MODE_DIRICHLET);
      if (p == 0) begin
         x_first  = s;
         ghost_lo = item.ghost_low;
      end else if (p == 1) begin
         x_second = s;
         if (ghost) begin
            push_point(weighted_sum(coef_next_q, s, coef_prev_q, ghost_lo, 0, 0), 0);
         end
      end else begin
         if (dir && p == 2) begin
            push_point(weighted_sum(coef_end0_q, x_first, coef_end1_q, x_second,
                                    coef_end2_q, s), 0);
         end
         push_point(weighted_sum(coef_next_q, s, coef_prev_q, x_older, 0, 0), p - 1);
      end
      if (p == last) begin
         if (dir) begin
            v = weighted_sum(coef_end0_q, s, coef_end1_q, x_newer, coef_end2_q, x_older);
         end else if (ghost) begin
            v = weighted_sum(coef_next_q, item.ghost_high, coef_prev_q, x_newer, 0, 0);
         end else begin
            v = weighted_sum(coef_next_q, x_first, coef_prev_q, x_newer, 0, 0);
         end
         push_point(v, last);
         if (!ghost && !dir) begin
            push_point(weighted_sum(coef_next_q, x_second, coef_prev_q, s, 0, 0), 0);
         end
         expected_points[$].line_done = 1'b1;
         line_pos = 0;
      end else begin
         line_pos = p + 1;
      end
      x_older = x_newer;
      x_newer = s;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] index,
                                     input logic [DATA_W-1:0] value);
      case (index)
         REG_BOUNDARY_MODE: mode_q = value[1:0];
         REG_LINE_LENGTH:   len_q = value[LEN_W-1:0];
         REG_COEF_NEXT:     coef_next_q = value;
         REG_COEF_PREV:     coef_prev_q = value;
         REG_COEF_END0:     coef_end0_q = value;
         REG_COEF_END1:     coef_end1_q = value;
         REG_COEF_END2:     coef_end2_q = value;
         default: ;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] rand_q16();
      logic [DATA_W-1:0] w;
      case ($urandom_range(5))
         0, 1: w = $urandom;
         2: begin
            case ($urandom_range(3))
               0: w = 32'h7FFF_FFFF;
               1: w = 32'h8000_0000;
               2: w = 32'h0000_0000;
               default: w = 32'hFFFF_FFFF;
            endcase
         end
         default: w = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      endcase
      return w;
   endfunction

   function automatic req_type random_item();
      req_type r;
      r.sample     = rand_q16();
      r.ghost_low  = rand_q16();
      r.ghost_high = rand_q16();
      return r;
   endfunction

   // Places a value in the low bits of a word whose upper bits are random.
   function automatic logic [DATA_W-1:0] with_noise(input int unsigned value,
                                                    input int unsigned width);
      logic [DATA_W-1:0] mask;
      mask = (32'd1 << width) - 32'd1;
      return (DATA_W'($urandom) & ~mask) | (DATA_W'(value) & mask);
   endfunction

   task automatic send_sample(input req_type item);
      @(negedge clock);
      if (idling) begin
         while ($urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predict_derivatives(item);
   endtask

   task automatic send_value(input logic [DATA_W-1:0] value);
      req_type item;
      item = random_item();
      item.sample = value;
      send_sample(item);
   endtask

   task automatic hold_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain_pipeline();
      hold_req();
      while (expected_points.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(index, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_coefs(input logic [DATA_W-1:0] next, input logic [DATA_W-1:0] prev,
                              input logic [DATA_W-1:0] end0, input logic [DATA_W-1:0] end1,
                              input logic [DATA_W-1:0] end2);
      write_reg(REG_COEF_NEXT, next);
      write_reg(REG_COEF_PREV, prev);
      write_reg(REG_COEF_END0, end0);
      write_reg(REG_COEF_END1, end1);
      write_reg(REG_COEF_END2, end2);
   endtask

   task automatic test_reset_values();
      repeat (2) send_value(rand_q16());
   endtask

   task automatic test_periodic_wrap();
      drain_pipeline();
      write_reg(REG_BOUNDARY_MODE, MODE_PERIODIC);
      write_reg(REG_LINE_LENGTH, 3);
      write_coefs(32'h0000_8000, 32'hFFFF_8000, 32'h0, 32'h0, 32'h0);
      send_value(32'h0001_0000);
      send_value(32'h0002_0000);
      send_value(32'hFFFD_0000);
      send_value(32'h0000_4000);
   endtask

   task automatic test_ghost_ends();
      req_type item;
      drain_pipeline();
      write_reg(REG_BOUNDARY_MODE, MODE_GHOST);
      write_coefs(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0);
      item = random_item();
      item.sample    = 32'h7FFF_FFFF;
      item.ghost_low = 32'h8000_0000;
      send_sample(item);
      send_value(32'h8000_0000);
      item = random_item();
      item.sample     = 32'h0000_0000;
      item.ghost_high = 32'h7FFF_FFFF;
      send_sample(item);
   endtask

   task automatic test_dirichlet_ends();
      drain_pipeline();
      write_reg(REG_BOUNDARY_MODE, MODE_DIRICHLET);
      write_coefs(32'h0000_8000, 32'hFFFF_8000, 32'hFFFE_8000, 32'h0002_0000, 32'hFFFF_8000);
      send_value(32'h0003_0000);
      send_value(32'hFFFF_0000);
      send_value(32'h0004_8000);
   endtask

   task automatic test_rounding_ties();
      drain_pipeline();
      write_reg(REG_BOUNDARY_MODE, MODE_PERIODIC);
      write_coefs(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_value(32'h0000_8000);
      send_value(32'hFFFF_8000);
      send_value(32'h0001_8000);
   endtask

   task automatic test_saturation();
      drain_pipeline();
      write_reg(REG_BOUNDARY_MODE, MODE_DIRICHLET);
      write_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_value(32'h7FFF_FFFF);
      send_value(32'h8000_0000);
      send_value(32'h7FFF_FFFF);
   endtask

   task automatic test_odd_settings();
      drain_pipeline();
      write_reg(REG_BOUNDARY_MODE, with_noise(MODE_RESERVED, 2));
      write_reg(REG_LINE_LENGTH, with_noise(1, LEN_W));
      write_reg(REG_UNUSED, $urandom);
      write_coefs(32'h0001_8000, 32'hFFFE_0000, 32'h0, 32'h0, 32'h0);
      repeat (3) send_value(rand_q16());
   endtask

   task automatic test_length_change_mid_line();
      drain_pipeline();
      write_reg(REG_BOUNDARY_MODE, MODE_PERIODIC);
      write_reg(REG_LINE_LENGTH, 12);
      repeat (4) send_value(rand_q16());
      drain_pipeline();
      write_reg(REG_LINE_LENGTH, 3);
      send_value(rand_q16());
   endtask

   // A long line under a length register above the maximum, closed early by
   // shortening the length once the position reaches 80.
   task automatic test_longest_line();
      drain_pipeline();
      write_reg(REG_LINE_LENGTH, 11'h7FF);
      write_coefs(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
      while (line_pos < 80) begin
         send_sample(random_item());
      end
      drain_pipeline();
      write_reg(REG_LINE_LENGTH, 3);
      send_sample(random_item());
   endtask

   task automatic test_random_lines();
      int unsigned sent;
      int unsigned items;
      int unsigned phase;
      int unsigned len;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         drain_pipeline();
         idling = (phase < 2) || (phase > 5);
         case ($urandom_range(9))
            0: len = $urandom_range(2);
            1: len = $urandom_range(64, 13);
            default: len = $urandom_range(10, 3);
         endcase
         write_reg(REG_BOUNDARY_MODE, with_noise($urandom_range(3), 2));
         write_reg(REG_LINE_LENGTH, with_noise(len, LEN_W));
         write_coefs(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16());
         if ($urandom_range(3) == 0) begin
            write_reg(REG_UNUSED, $urandom);
         end
         items = $urandom_range(3 * clamped_length() + 2, 1);
         for (int i = 0; i < items; i++) begin
            send_sample(random_item());
            if (phase == 1 && i == items / 2) begin
               drain_pipeline();
            end
         end
         sent += items;
         phase++;
      end
      idling = 1'b1;
   endtask

   always @(negedge clock) begin
      rsp_ready <= !idling || ($urandom_range(99) >= 30);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_points.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
               $display("unexpected result: derivative %0d point %0d done %0b",
                        rsp_data.derivative, rsp_data.point_index, rsp_data.line_done);
            end
         end else begin
            want = expected_points.pop_front();
            if (rsp_data.derivative !== want.derivative
                || rsp_data.point_index !== want.point_index
                || rsp_data.line_done !== want.line_done) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected derivative %0d point %0d done %0b, got %0d %0d %0b",
                           want.derivative, want.point_index, want.line_done,
                           rsp_data.derivative, rsp_data.point_index, rsp_data.line_done);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_periodic_wrap();
      test_ghost_ends();
      test_dirichlet_ends();
      test_rounding_ties();
      test_saturation();
      test_odd_settings();
      test_length_change_mid_line();
      test_longest_line();
      test_random_lines();
      drain_pipeline();
      if (error_count == 0 && expected_points.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
